[hw/rtl/b32c_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b32c_pkg;

  localparam int ID_BYTES_DEF = 20;

  // widths of the block state
  localparam int BITS_W = 12;
  localparam int CNT_W  = 4;
  localparam int POS_W  = 7;
  localparam int SYM_W  = 5;
  localparam int BYTE_W = 8;
  localparam int MAX_RES = 3;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_Z    = 8'h7a;
  localparam logic [BYTE_W-1:0] CHAR_TWO  = 8'h32;
  localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [SYM_W-1:0]  SYM_LETTERS = 5'd26;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              run_last;
    logic              block_last;
  } res_t;

  typedef struct packed {
    logic [1:0]             n_res;
    res_t [MAX_RES-1:0]     res;
    logic [BITS_W-1:0]      bits;
    logic [CNT_W-1:0]       nbits;
    logic [POS_W-1:0]       pos;
  } step_t;

  function automatic logic [BITS_W-1:0] low_mask(input logic [CNT_W-1:0] s);
    logic [BITS_W:0] one;
    one = (BITS_W+1)'(1) << s;
    return BITS_W'(one - (BITS_W+1)'(1));
  endfunction

  function automatic logic [BYTE_W-1:0] sym_to_char(input logic [SYM_W-1:0] v);
    logic [BYTE_W-1:0] c;
    if (v < SYM_LETTERS) begin
      c = CHAR_A + BYTE_W'(v);
    end else begin
      c = CHAR_TWO + BYTE_W'(v - SYM_LETTERS);
    end
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] char_to_sym(input logic [BYTE_W-1:0] c);
    logic [SYM_W-1:0] s;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      s = SYM_W'(c - CHAR_A);
    end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
      s = SYM_W'(c - CHAR_TWO) + SYM_LETTERS;
    end else begin
      s = '0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/b32c_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module b32c_step #(
  parameter int ID_BYTES = b32c_pkg::ID_BYTES_DEF
) (
  input  wire logic                          dir,
  input  wire logic [b32c_pkg::BYTE_W-1:0]   in_value,
  input  wire logic [b32c_pkg::BITS_W-1:0]   bits,
  input  wire logic [b32c_pkg::CNT_W-1:0]    nbits,
  input  wire logic [b32c_pkg::POS_W-1:0]    pos,
  output b32c_pkg::step_t                    step
);

  localparam int CHAR_COUNT = (ID_BYTES * 8 + 4) / 5;
  localparam logic [b32c_pkg::POS_W-1:0] ENC_LAST = b32c_pkg::POS_W'(ID_BYTES - 1);
  localparam logic [b32c_pkg::POS_W-1:0] DEC_LAST = b32c_pkg::POS_W'(CHAR_COUNT - 1);

  always_comb begin
    logic [b32c_pkg::BITS_W-1:0] acc;
    logic [b32c_pkg::BITS_W-1:0] acc2;
    logic [b32c_pkg::BITS_W-1:0] acc3;
    logic [b32c_pkg::CNT_W-1:0]  cnt;
    logic [b32c_pkg::CNT_W-1:0]  c1;
    logic [b32c_pkg::CNT_W-1:0]  c2;
    logic [b32c_pkg::BYTE_W-1:0] val [b32c_pkg::MAX_RES];
    logic [1:0]                  n;
    logic                        last;

    acc  = bits & b32c_pkg::low_mask({1'b0, nbits[2:0]});
    cnt  = nbits;
    n    = 2'd0;
    c1   = '0;
    c2   = '0;
    acc2 = '0;
    acc3 = '0;
    for (int i = 0; i < b32c_pkg::MAX_RES; i++) begin
      val[i] = '0;
    end

    if (dir == b32c_pkg::DIR_ENCODE) begin
      if (cnt > 4'd4) begin
        cnt = '0;
        acc = '0;
      end
      last = (pos >= ENC_LAST);
      acc2 = b32c_pkg::BITS_W'({acc, in_value});
      cnt  = cnt + 4'd8;
      // first character always comes out
      c1     = cnt - 4'd5;
      val[0] = b32c_pkg::sym_to_char(b32c_pkg::SYM_W'(acc2 >> c1));
      acc3   = acc2 & b32c_pkg::low_mask(c1);
      n      = 2'd1;
      cnt    = c1;
      if (c1 >= 4'd5) begin
        c2     = c1 - 4'd5;
        val[1] = b32c_pkg::sym_to_char(b32c_pkg::SYM_W'(acc3 >> c2));
        acc3   = acc3 & b32c_pkg::low_mask(c2);
        n      = 2'd2;
        cnt    = c2;
      end
      // leftover bits padded with zeros on the right
      if (last && cnt != '0) begin
        val[n] = b32c_pkg::sym_to_char(b32c_pkg::SYM_W'(acc3 << (4'd5 - cnt)));
        n      = n + 2'd1;
        cnt    = '0;
      end
    end else begin
      if (cnt > 4'd7) begin
        cnt = '0;
        acc = '0;
      end
      last = (pos >= DEC_LAST);
      acc2 = b32c_pkg::BITS_W'({acc, b32c_pkg::char_to_sym(in_value)});
      cnt  = cnt + 4'd5;
      acc3 = acc2;
      if (cnt >= 4'd8) begin
        c1     = cnt - 4'd8;
        val[0] = b32c_pkg::BYTE_W'(acc2 >> c1);
        acc3   = acc2 & b32c_pkg::low_mask(c1);
        n      = 2'd1;
        cnt    = c1;
      end
    end

    step.n_res = n;
    for (int i = 0; i < b32c_pkg::MAX_RES; i++) begin
      step.res[i].value      = val[i];
      step.res[i].run_last   = (2'(i) == n - 2'd1);
      step.res[i].block_last = (2'(i) == n - 2'd1) && last;
    end

    if (last) begin
      step.bits  = '0;
      step.nbits = '0;
      step.pos   = '0;
    end else begin
      step.bits  = acc3;
      step.nbits = cnt;
      step.pos   = pos + b32c_pkg::POS_W'(1);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/base32_block_codec_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// in_       in   tvalid / tready    tdata[7:0] = in_value
// out_      out  tvalid / tready    tdata[7:0] = out_value, tuser = run_last,
//                                   tlast = block_last
// cfg_      in   wr_en              wr_data[0] = direction (0 encode, 1 decode)
//
// each item is converted in the cycle it is accepted; its zero to three results
// sit in a three-entry result register and leave from the next cycle, one per
// cycle while out_tready is high; a new item is taken once the result register
// is empty or giving up its last entry
// reset clears direction, the bit accumulator, the block position and the results
// a write on cfg_ also restarts the block; out_tready low holds the current result

module base32_block_codec_unit #(
  parameter int ID_BYTES = b32c_pkg::ID_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_value
  output logic             out_tuser,  // [0] run_last
  output logic             out_tlast,  // block_last
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_wr_data // [0] direction
);

  logic                          dir_r;
  logic [b32c_pkg::BITS_W-1:0]   bits_r;
  logic [b32c_pkg::CNT_W-1:0]    nbits_r;
  logic [b32c_pkg::POS_W-1:0]    pos_r;
  b32c_pkg::res_t [b32c_pkg::MAX_RES-1:0] q_r, q_nxt;
  logic [1:0]                    qn_r, qn_nxt;
  b32c_pkg::step_t               step;
  logic                          accept;
  logic                          pop;

  b32c_step #(
    .ID_BYTES (ID_BYTES)
  ) u_step (
    .dir      (dir_r),
    .in_value (in_tdata),
    .bits     (bits_r),
    .nbits    (nbits_r),
    .pos      (pos_r),
    .step     (step)
  );

  assign out_tvalid = (qn_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (qn_r == 2'd0) || (qn_r == 2'd1 && out_tready);
  assign accept     = in_tvalid && in_tready;

  assign out_tdata = q_r[0].value;
  assign out_tuser = q_r[0].run_last;
  assign out_tlast = q_r[0].block_last;

  always_comb begin
    q_nxt  = q_r;
    qn_nxt = qn_r;
    if (accept && step.n_res != 2'd0) begin
      q_nxt  = step.res;
      qn_nxt = step.n_res;
    end else if (pop) begin
      // shift the queue down by one entry
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      qn_nxt   = qn_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= b32c_pkg::DIR_ENCODE;
      bits_r  <= '0;
      nbits_r <= '0;
      pos_r   <= '0;
      qn_r    <= '0;
    end else begin
      qn_r <= qn_nxt;
      if (cfg_wr_en) begin
        dir_r   <= cfg_wr_data[0];
        bits_r  <= '0;
        nbits_r <= '0;
        pos_r   <= '0;
      end else if (accept) begin
        bits_r  <= step.bits;
        nbits_r <= step.nbits;
        pos_r   <= step.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

`default_nettype wire
